### hw/rtl/rgb_to_hsv_convert_defines.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RHSV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RHSV_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHSV_ASSERT(label, clk, rstn, prop, msg)
`define RHSV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### hw/rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Widths and constants of the pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;
    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 9;
    localparam int NUM_W   = 17;
    localparam int DIV_STAGES = HUE_W;
    localparam logic [HUE_W-1:0] HUE_TURN = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECT = 9'd60;
    localparam logic [CHAN_W-1:0] SAT_SCALE = 8'd255;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [HUE_W-1:0]  quo_t;
endpackage

### hw/rtl/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Streams 8-bit RGB pixels in and HSV pixels out, one per clock unless the pipeline holds.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock unless the pipeline holds. One stage finds
// max, min and the two dividends, then nine restoring-division stages each
// resolve one quotient bit of hue and saturation in parallel. The whole
// pipeline holds when m_tready is low and the output is occupied.
`include "rgb_to_hsv_convert_defines.svh"

module rgb_to_hsv_convert
    import rgbhsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue_deg[8:0], saturation[16:9], brightness[24:17]
);
    localparam int NS = DIV_STAGES + 1;

    logic  vld_reg   [NS];
    num_t  hrem_reg  [NS];
    chan_t hdiv_reg  [NS];
    quo_t  hq_reg    [NS];
    num_t  srem_reg  [NS];
    chan_t sdiv_reg  [NS];
    quo_t  sq_reg    [NS];
    chan_t bright_reg[NS];

    logic  adv;
    chan_t r, g, b, mx, mn, dl;
    num_t  hnum_next;
    num_t  snum_next;
    logic  [HUE_W-1:0] hbase;
    chan_t hp, hq;
    num_t  hsh [NS-1];
    num_t  ssh [NS-1];
    logic  hge [NS-1];
    logic  sge [NS-1];

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign r = s_tdata[7:0];
    assign g = s_tdata[15:8];
    assign b = s_tdata[23:16];

    always_comb begin
        mx = (r >= g) ? r : g;
        mx = (mx >= b) ? mx : b;
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        dl = mx - mn;
        if (r == mx) begin
            hbase = (g >= b) ? '0 : HUE_TURN;
            hp = g;
            hq = b;
        end else if (g == mx) begin
            hbase = HUE_SECT + HUE_SECT;
            hp = b;
            hq = r;
        end else begin
            hbase = HUE_SECT + HUE_SECT + HUE_SECT + HUE_SECT;
            hp = r;
            hq = g;
        end
        hnum_next = num_t'(hbase) * num_t'(dl)
                  + num_t'(HUE_SECT) * num_t'(hp) - num_t'(HUE_SECT) * num_t'(hq);
        snum_next = num_t'(SAT_SCALE) * num_t'(dl);
    end

    always_comb begin
        for (int k = 1; k < NS; k++) begin
            hsh[k-1] = num_t'(hdiv_reg[k-1]) << (NS - 1 - k);
            ssh[k-1] = num_t'(sdiv_reg[k-1]) << (NS - 1 - k);
            hge[k-1] = hrem_reg[k-1] >= hsh[k-1];
            sge[k-1] = srem_reg[k-1] >= ssh[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        if (adv) begin
            bright_reg[0] <= mx;
            hq_reg[0]     <= '0;
            sq_reg[0]     <= '0;
            if (dl == '0) begin
                hrem_reg[0] <= '0;
                srem_reg[0] <= '0;
                hdiv_reg[0] <= CHAN_W'(1);
                sdiv_reg[0] <= CHAN_W'(1);
            end else begin
                hrem_reg[0] <= hnum_next;
                srem_reg[0] <= snum_next;
                hdiv_reg[0] <= dl;
                sdiv_reg[0] <= mx;
            end
            for (int k = 1; k < NS; k++) begin
                hdiv_reg[k]   <= hdiv_reg[k-1];
                sdiv_reg[k]   <= sdiv_reg[k-1];
                bright_reg[k] <= bright_reg[k-1];
                hrem_reg[k]   <= hge[k-1] ? hrem_reg[k-1] - hsh[k-1] : hrem_reg[k-1];
                srem_reg[k]   <= sge[k-1] ? srem_reg[k-1] - ssh[k-1] : srem_reg[k-1];
                hq_reg[k]     <= hq_reg[k-1] | (quo_t'(hge[k-1]) << (NS - 1 - k));
                sq_reg[k]     <= sq_reg[k-1] | (quo_t'(sge[k-1]) << (NS - 1 - k));
            end
        end
    end

    quo_t hue_out;
    assign hue_out  = (hq_reg[NS-1] >= HUE_TURN) ? '0 : hq_reg[NS-1];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {7'd0, bright_reg[NS-1], sq_reg[NS-1][CHAN_W-1:0], hue_out};

    `RHSV_ASSERT(a_ready, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `RHSV_ASSERT(a_hue_rng, aclk, aresetn, m_tvalid |-> (hq_reg[NS-1] < HUE_TURN), "hue range")
    `RHSV_ASSERT(a_sat_fit, aclk, aresetn, m_tvalid |-> (sq_reg[NS-1][HUE_W-1] == 1'b0), "sat range")
    `RHSV_ASSERT(a_black, aclk, aresetn, (m_tvalid && bright_reg[NS-1] == '0) |-> (m_tdata[16:0] == '0), "black pixel")
endmodule

### tb/tb_rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives RGB pixels through the stream input, predicts hue, saturation and
// brightness with exact floor arithmetic, and checks every output transfer
// in order under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_convert;
    import rgbhsv_pkg::*;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       known;
        hsv_t       res;
    } pixel_row_t;

    localparam int RANDOM_PIXELS = 1000;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    hsv_t hsv_pending[$];
    int   error_count;
    int   idle_cycles;
    int   phase;
    bit   hold_out;
    bit   sending_done;

    rgb_to_hsv_convert DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsv_t o;
        int   mx;
        int   mn;
        int   delta;
        int   num;
        int   hue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        o.val = 8'(mx);
        o.sat = '0;
        o.hue = '0;
        if (delta != 0) begin
            o.sat = 8'((255 * delta) / mx);
            if (r == mx) begin
                num = 60 * (int'(g) - int'(b));
                if (num < 0) num = num + 360 * delta;
            end else if (g == mx) begin
                num = 120 * delta + 60 * (int'(b) - int'(r));
            end else begin
                num = 240 * delta + 60 * (int'(r) - int'(g));
            end
            hue = num / delta;
            if (hue >= 360) hue = 0;
            o.hue = 9'(hue);
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (phase < 2 && ((phase == 0) ? ($urandom_range(99) < 19)
                                           : ($urandom_range(99) < 73))) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hsv_pending.push_back(convert_pixel(r, g, b));
    endtask

    pixel_row_t pixel_table[] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{9'd0,   8'd0,   8'd255}},
        '{8'd77,  8'd77,  8'd77,  1'b1, '{9'd0,   8'd0,   8'd77}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{9'd0,   8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{9'd120, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{9'd240, 8'd255, 8'd255}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{9'd60,  8'd255, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{9'd180, 8'd255, 8'd255}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{9'd300, 8'd255, 8'd255}},
        '{8'd255, 8'd254, 8'd254, 1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd255, 8'd254, 8'd255, 1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd255, 8'd0,   8'd1,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd1,   8'd0,   8'd0,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd0,   8'd1,   8'd1,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd1,   8'd0,   8'd255, 1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd0,   8'd255, 8'd1,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd254, 8'd255, 8'd0,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd170, 8'd85,  8'd0,   1'b0, '{9'd0, 8'd0, 8'd0}},
        '{8'd200, 8'd100, 8'd201, 1'b0, '{9'd0, 8'd0, 8'd0}}
    };

    initial begin
        int         k;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        error_count  = 0;
        phase        = 0;
        sending_done = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (pixel_table[i]) begin
            if (pixel_table[i].known && convert_pixel(pixel_table[i].r, pixel_table[i].g,
                    pixel_table[i].b) != pixel_table[i].res)
                report_mismatch("directed prediction", i, -1);
            send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
        end
        for (k = 0; k < RANDOM_PIXELS; k++) begin
            if (k == RANDOM_PIXELS / 3) phase = 1;
            if (k == 2 * RANDOM_PIXELS / 3) phase = 2;
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            case ($urandom_range(7))
                0: g = r;
                1: b = g;
                2: begin g = r; b = r; end
                3: b = 8'($urandom_range(255)) & 8'h0f;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        s_tvalid     <= 1'b0;
        sending_done = 1;
    end

    initial begin
        hold_out = 0;
        wait (phase == 2);
        @(posedge aclk);
        hold_out <= 1;
        repeat (200) @(posedge aclk);
        hold_out <= 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_out) begin
            m_tready <= 1'b0;
        end else begin
            case (phase)
                0: m_tready <= ($urandom_range(99) >= 73);
                1: m_tready <= ($urandom_range(99) >= 19);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        hsv_t got;
        hsv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[8:0], m_tdata[16:9], m_tdata[24:17]};
            if (hsv_pending.size() == 0) begin
                report_mismatch("unexpected transfer", got, -1);
            end else begin
                want = hsv_pending.pop_front();
                if (got.hue != want.hue) report_mismatch("hue_deg", got.hue, want.hue);
                if (got.sat != want.sat) report_mismatch("saturation", got.sat, want.sat);
                if (got.val != want.val) report_mismatch("brightness", got.val, want.val);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog expired");
                $display("rgb_to_hsv_convert verification failed");
                $finish;
            end
            if (sending_done && hsv_pending.size() == 0) begin
                repeat (DRAIN_CYCLES) @(posedge aclk);
                if (error_count == 0)
                    $display("rgb_to_hsv_convert verification clean");
                else
                    $display("rgb_to_hsv_convert verification failed");
                $finish;
            end
        end
    end
endmodule
